// ===== rtl/awt_pkg.sv =====
// Package for the allocation watch table: table entry, op codes, status codes, sequencer states.
package awt_pkg;

  localparam int DEF_SLOTS  = 64;
  localparam int DEF_OWNERS = 64;

  localparam int ADDR_W  = 64;
  localparam int OWNER_W = 6;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_PURGE = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic               valid;
    logic [OWNER_W-1:0] owner;
    logic [ADDR_W-1:0]  base;
  } entry_t;

endpackage

// ===== rtl/alloc_watch_table.sv =====
// Allocation watch table: slot memory with a sequential scan engine.
//
// Input channel (in_valid / in_stall): one beat carries op, address and owner.
// A beat is taken when in_valid is high and in_stall is low; in_stall is low
// only while the engine is idle, so one item is in work at a time.
// Output channel (out_valid / out_stall): one beat per item with status,
// slot, purged and active_count, held in an output register.
//
// Each item walks the slot memory from slot 0, one read per cycle; the read
// data is registered and comes in the next cycle, and a hit writes back in
// that same cycle. Alloc stops at the first free slot and free at the first
// matching slot; a miss, and every purge, walks every slot; an unused op goes
// straight to its result. The next beat can be taken in the cycle after the
// result is loaded; throughput is set by the one-read-per-cycle memory walk.
//
// Reset starts a clearing pass that writes every slot invalid, one slot per
// cycle; in_stall stays high during it. The active count resets to zero.
// While the receiver stalls a finished result, the result register holds it
// and the engine waits before returning to idle.
module alloc_watch_table
  import awt_pkg::*;
#(
  parameter int SLOTS  = DEF_SLOTS,
  parameter int OWNERS = DEF_OWNERS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [OP_W-1:0]    op,
  input  logic [ADDR_W-1:0]  address,
  input  logic [OWNER_W-1:0] owner,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [5:0]         slot,
  output logic [6:0]         purged,
  output logic [6:0]         active_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW:0]   SLOTS_W = (IW+1)'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  entry_t mem [SLOTS];
  entry_t mem_q;
  logic           we;
  logic [IW-1:0]  waddr;
  entry_t         wdata;
  logic           re;
  logic [IW-1:0]  raddr;

  seq_state_t     state, state_next;
  logic [IW:0]    issue, issue_next;
  logic           pend, pend_next;
  logic [IW-1:0]  pidx, pidx_next;
  logic [CW-1:0]  cnt, cnt_next;
  logic [CW-1:0]  pcount, pcount_next;
  status_t        res_status, res_status_next;
  logic [IW-1:0]  res_slot, res_slot_next;

  logic [OP_W-1:0]    cur_op;
  logic [ADDR_W-1:0]  cur_addr;
  logic [OWNER_W-1:0] cur_owner;
  logic               cur_owner_ok;

  logic accept;
  logic out_load;
  logic base_hit;
  logic owner_hit;
  logic [IW+5:0] slot_ext;
  logic [CW+6:0] purged_ext;
  logic [CW+6:0] count_ext;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign base_hit  = (mem_q.base == cur_addr);
  assign owner_hit = (mem_q.owner == cur_owner);

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  always_comb begin
    state_next      = state;
    issue_next      = issue;
    pend_next       = 1'b0;
    pidx_next       = pidx;
    cnt_next        = cnt;
    pcount_next     = pcount;
    res_status_next = res_status;
    res_slot_next   = res_slot;
    we              = 1'b0;
    waddr           = pidx;
    wdata           = mem_q;
    re              = 1'b0;
    raddr           = issue[IW-1:0];

    unique case (state)
      S_CLEAR: begin
        we         = 1'b1;
        waddr      = issue[IW-1:0];
        wdata      = '0;
        issue_next = issue + 1'b1;
        if (issue[IW-1:0] == LAST_IDX) begin
          issue_next = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          issue_next      = '0;
          pcount_next     = '0;
          res_status_next = ST_OK;
          res_slot_next   = '0;
          if (op == OP_ALLOC || op == OP_FREE || op == OP_PURGE) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (issue < SLOTS_W) begin
          re         = 1'b1;
          pend_next  = 1'b1;
          pidx_next  = issue[IW-1:0];
          issue_next = issue + 1'b1;
        end
        if (pend) begin
          priority if (cur_op == OP_ALLOC) begin
            if (!mem_q.valid) begin
              we            = 1'b1;
              wdata.valid   = 1'b1;
              wdata.owner   = cur_owner;
              wdata.base    = cur_addr;
              cnt_next      = cnt + 1'b1;
              res_slot_next = pidx;
              pend_next     = 1'b0;
              state_next    = S_DONE;
            end else if (pidx == LAST_IDX) begin
              res_status_next = ST_FULL;
              pend_next       = 1'b0;
              state_next      = S_DONE;
            end
          end else if (cur_op == OP_FREE) begin
            if (mem_q.valid && base_hit && owner_hit) begin
              we          = 1'b1;
              wdata.valid = 1'b0;
              if (cnt != '0) begin
                cnt_next = cnt - 1'b1;
              end
              res_slot_next = pidx;
              pend_next     = 1'b0;
              state_next    = S_DONE;
            end else if (pidx == LAST_IDX) begin
              res_status_next = ST_NOMATCH;
              pend_next       = 1'b0;
              state_next      = S_DONE;
            end
          end else begin
            // purge: clear every hit and keep walking to the last slot
            if (mem_q.valid && owner_hit && cur_owner_ok) begin
              we          = 1'b1;
              wdata.valid = 1'b0;
              if (cnt != '0) begin
                cnt_next = cnt - 1'b1;
              end
              pcount_next = pcount + 1'b1;
            end
            if (pidx == LAST_IDX) begin
              pend_next  = 1'b0;
              state_next = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      issue <= '0;
      pend  <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      issue <= issue_next;
      pend  <= pend_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pidx       <= pidx_next;
    pcount     <= pcount_next;
    res_status <= res_status_next;
    res_slot   <= res_slot_next;
    if (accept) begin
      cur_op       <= op;
      cur_addr     <= address;
      cur_owner    <= owner;
      cur_owner_ok <= (32'(owner) < OWNERS);
    end
  end

  assign slot_ext   = {6'b0, res_slot};
  assign purged_ext = {7'b0, (cur_op == OP_PURGE) ? pcount : {CW{1'b0}}};
  assign count_ext  = {7'b0, cnt};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      slot         <= slot_ext[5:0];
      purged       <= purged_ext[6:0];
      active_count <= count_ext[6:0];
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= SLOTS_C)
    else $error("active count above slot count");

  a_pend_scan: assert property (@(posedge clk) disable iff (rst)
    (state != S_SCAN) |-> !pend)
    else $error("read pending outside scan");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SCAN || state == S_DONE))
    else $error("accepted beat did not start work");

  a_done_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("result load did not raise out_valid");

endmodule

// ===== verif/alloc_watch_table_tb.sv =====
// Testbench for alloc_watch_table: directed table plus random alloc/free/purge traffic.
`timescale 1ns / 100ps

module alloc_watch_table_tb;
  import awt_pkg::*;

  localparam int SLOTS          = DEF_SLOTS;
  localparam int ITEMS          = 1950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int LONG_HOLD      = 400;
  localparam int DIR_ROWS       = 21;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_MAX = {ADDR_W{1'b1}};

  typedef struct packed {
    logic [1:0] code;
    logic [5:0] idx;
    logic [6:0] cleared;
    logic [6:0] live;
  } table_reply_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  addr;
    logic [OWNER_W-1:0] who;
    logic               fixed;
    table_reply_t       want;
  } stim_row_t;

  typedef enum int { PH_FILL, PH_DRAIN, PH_MIX } phase_kind_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [OP_W-1:0]    op;
  logic [ADDR_W-1:0]  address;
  logic [OWNER_W-1:0] owner;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         status;
  logic [5:0]         slot;
  logic [6:0]         purged;
  logic [6:0]         active_count;

  // shadow copy of the slot table
  logic               shadow_valid [SLOTS];
  logic [ADDR_W-1:0]  shadow_base  [SLOTS];
  logic [OWNER_W-1:0] shadow_owner [SLOTS];
  int                 shadow_count;

  table_reply_t       expected_replies [$];
  logic [ADDR_W-1:0]  addr_pool [8];
  logic [OWNER_W-1:0] owner_pool [4];
  bit                 use_owner_pool;
  bit                 tx_no_gaps;
  int                 items_sent;
  int                 replies_seen = 0;
  int                 errors = 0;
  int                 quiet_cycles = 0;

  stim_row_t stim_rows [0:DIR_ROWS-1] = '{
    '{OP_FREE,   64'h0,     6'd0,  1'b1, '{ST_NOMATCH, 6'd0, 7'd0, 7'd0}},
    '{OP_PURGE,  64'h0,     6'd5,  1'b1, '{ST_OK,      6'd0, 7'd0, 7'd0}},
    '{OP_UNUSED, ADDR_MAX,  6'd63, 1'b1, '{ST_OK,      6'd0, 7'd0, 7'd0}},
    '{OP_ALLOC,  64'h0,     6'd0,  1'b0, '0},
    '{OP_ALLOC,  ADDR_MAX,  6'd63, 1'b1, '{ST_OK,      6'd1, 7'd0, 7'd2}},
    '{OP_ALLOC,  ADDR_MAX,  6'd0,  1'b0, '0},
    '{OP_FREE,   ADDR_MAX,  6'd5,  1'b1, '{ST_NOMATCH, 6'd0, 7'd0, 7'd3}},
    '{OP_FREE,   64'h0,     6'd63, 1'b1, '{ST_NOMATCH, 6'd0, 7'd0, 7'd3}},
    '{OP_FREE,   ADDR_MAX,  6'd63, 1'b0, '0},
    '{OP_ALLOC,  64'h8000_0000_0000_0001, 6'd63, 1'b0, '0},
    '{OP_FREE,   ADDR_MAX,  6'd63, 1'b1, '{ST_NOMATCH, 6'd0, 7'd0, 7'd3}},
    '{OP_ALLOC,  64'h0,     6'd0,  1'b0, '0},
    '{OP_FREE,   64'h0,     6'd0,  1'b0, '0},
    '{OP_PURGE,  64'h0,     6'd63, 1'b0, '0},
    '{OP_UNUSED, 64'h0,     6'd0,  1'b0, '0},
    '{OP_PURGE,  ADDR_MAX,  6'd0,  1'b0, '0},
    '{OP_PURGE,  64'h0,     6'd0,  1'b0, '0},
    '{OP_ALLOC,  64'h5555_5555_5555_5555, 6'h2a, 1'b0, '0},
    '{OP_ALLOC,  64'haaaa_aaaa_aaaa_aaaa, 6'h15, 1'b0, '0},
    '{OP_PURGE,  64'h0,     6'h2a, 1'b0, '0},
    '{OP_PURGE,  64'h0,     6'h15, 1'b0, '0}
  };

  alloc_watch_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .address      (address),
    .owner        (owner),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .slot         (slot),
    .purged       (purged),
    .active_count (active_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one op to the shadow table and return the reply the block owes.
  function automatic table_reply_t apply_table_op(input logic [OP_W-1:0] o,
                                                  input logic [ADDR_W-1:0] a,
                                                  input logic [OWNER_W-1:0] w);
    table_reply_t r;
    r = '0;
    r.code = ST_OK;
    case (o)
      OP_ALLOC: begin
        r.code = ST_FULL;
        for (int i = 0; i < SLOTS; i++) begin
          if (!shadow_valid[i]) begin
            shadow_valid[i] = 1'b1;
            shadow_base[i]  = a;
            shadow_owner[i] = w;
            shadow_count++;
            r.code = ST_OK;
            r.idx  = 6'(i);
            break;
          end
        end
      end
      OP_FREE: begin
        r.code = ST_NOMATCH;
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_valid[i] && shadow_base[i] == a && shadow_owner[i] == w) begin
            shadow_valid[i] = 1'b0;
            shadow_count--;
            r.code = ST_OK;
            r.idx  = 6'(i);
            break;
          end
        end
      end
      OP_PURGE: begin
        if (int'(w) < DEF_OWNERS) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (shadow_valid[i] && shadow_owner[i] == w) begin
              shadow_valid[i] = 1'b0;
              shadow_count--;
              r.cleared++;
            end
          end
        end
      end
      default: ;
    endcase
    r.live = 7'(shadow_count);
    return r;
  endfunction

  // mostly back to back, sometimes a short gap, rarely a long pause
  function automatic int idle_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    if ($urandom_range(99) < 30) return addr_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [OWNER_W-1:0] pick_owner();
    if (use_owner_pool) return owner_pool[$urandom_range(3)];
    return OWNER_W'($urandom_range(63));
  endfunction

  // random valid slot, or -1 when the table is empty
  function automatic int live_slot();
    int idx [$];
    for (int i = 0; i < SLOTS; i++)
      if (shadow_valid[i]) idx.push_back(i);
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(idx.size() - 1)];
  endfunction

  task automatic send_item(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
                           input logic [OWNER_W-1:0] w, input bit fixed,
                           input table_reply_t want);
    int gap;
    table_reply_t pred;
    gap = tx_no_gaps ? 0 : idle_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op       = o;
    address  = a;
    owner    = w;
    do @(posedge clk); while (in_stall);
    pred = apply_table_op(o, a, w);
    expected_replies.push_back(fixed ? want : pred);
    items_sent++;
  endtask

  task automatic send_op(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
                         input logic [OWNER_W-1:0] w);
    send_item(o, a, w, 1'b0, '0);
  endtask

  // Purge every owner still present, fill the whole table with one owner,
  // overflow it, then purge that owner: full table and a full purge.
  task automatic wipe_and_fill();
    bit present;
    logic [OWNER_W-1:0] w0;
    for (int w = 0; w < 64; w++) begin
      present = 1'b0;
      for (int i = 0; i < SLOTS; i++)
        if (shadow_valid[i] && shadow_owner[i] == OWNER_W'(w)) present = 1'b1;
      if (present) send_op(OP_PURGE, pick_addr(), OWNER_W'(w));
    end
    w0 = OWNER_W'($urandom_range(63));
    repeat (SLOTS + $urandom_range(1, 3)) send_op(OP_ALLOC, pick_addr(), w0);
    send_op(OP_PURGE, pick_addr(), w0);
  endtask

  task automatic random_phase(input phase_kind_t kind);
    int n, r, s, pa, pf, pn, pp;
    logic [ADDR_W-1:0] a;
    logic [OWNER_W-1:0] w;
    case (kind)
      PH_FILL:  begin n = $urandom_range(70, 100); pa = 82; pf = 8;  pn = 4;  pp = 3; end
      PH_DRAIN: begin n = $urandom_range(40, 80);  pa = 8;  pf = 70; pn = 10; pp = 9; end
      default:  begin n = $urandom_range(30, 60);  pa = 40; pf = 35; pn = 12; pp = 10; end
    endcase
    repeat (n) begin
      r = $urandom_range(99);
      s = live_slot();
      if (r < pa) begin
        send_op(OP_ALLOC, pick_addr(), pick_owner());
      end else if (r < pa + pf) begin
        if (s >= 0) send_op(OP_FREE, shadow_base[s], shadow_owner[s]);
        else send_op(OP_FREE, pick_addr(), pick_owner());
      end else if (r < pa + pf + pn) begin
        // near misses: live address under another owner, or a stray address
        if (s >= 0 && $urandom_range(1)) begin
          a = shadow_base[s];
          w = shadow_owner[s] + OWNER_W'($urandom_range(1, 63));
        end else begin
          a = pick_addr();
          w = pick_owner();
        end
        send_op(OP_FREE, a, w);
      end else if (r < pa + pf + pn + pp) begin
        if (s >= 0 && $urandom_range(3) != 0) send_op(OP_PURGE, pick_addr(), shadow_owner[s]);
        else send_op(OP_PURGE, pick_addr(), pick_owner());
      end else begin
        send_op(OP_UNUSED, {$urandom, $urandom}, OWNER_W'($urandom_range(63)));
      end
    end
  endtask

  // reply checker
  always @(posedge clk) begin : reply_check
    table_reply_t want;
    if (!rst && out_valid && !out_stall) begin
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $display("%0t: reply with nothing pending: status %0d slot %0d purged %0d count %0d",
                 $time, status, slot, purged, active_count);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.code) begin
          $display("%0t: status expected %0d actual %0d", $time, want.code, status);
          errors++;
        end
        if (slot !== want.idx) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.idx, slot);
          errors++;
        end
        if (purged !== want.cleared) begin
          $display("%0t: purged expected %0d actual %0d", $time, want.cleared, purged);
          errors++;
        end
        if (active_count !== want.live) begin
          $display("%0t: active_count expected %0d actual %0d", $time, want.live,
                   active_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("alloc_watch_table test failed");
      $finish;
    end
  end

  // receiver: random stalls, calm stretches, one long hold-off to back up the input
  initial begin : rx_side
    int hold, calm;
    bit long_hold_done;
    out_stall      = 1'b0;
    hold           = 0;
    calm           = 0;
    long_hold_done = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (!long_hold_done && replies_seen >= 200) begin
        long_hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
      end else if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else if (calm > 0) begin
        calm--;
        out_stall = 1'b0;
      end else if ($urandom_range(99) < 10) begin
        calm = $urandom_range(50, 300);
        out_stall = 1'b0;
      end else begin
        hold = idle_gap();
        out_stall = (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  initial begin
    int r;
    rst            = 1'b1;
    in_valid       = 1'b0;
    op             = OP_ALLOC;
    address        = '0;
    owner          = '0;
    items_sent     = 0;
    shadow_count   = 0;
    use_owner_pool = 1'b0;
    tx_no_gaps     = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_base[i]  = '0;
      shadow_owner[i] = '0;
    end
    addr_pool[0] = '0;
    addr_pool[1] = ADDR_MAX;
    for (int i = 2; i < 8; i++) addr_pool[i] = {$urandom, $urandom};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(stim_rows[i].op, stim_rows[i].addr, stim_rows[i].who,
                stim_rows[i].fixed, stim_rows[i].want);

    wipe_and_fill();
    while (items_sent < ITEMS) begin
      use_owner_pool = $urandom_range(1);
      for (int i = 0; i < 4; i++) owner_pool[i] = OWNER_W'($urandom_range(63));
      tx_no_gaps = ($urandom_range(3) == 0);
      r = $urandom_range(99);
      if (r < 8) wipe_and_fill();
      else if (r < 40) random_phase(PH_FILL);
      else if (r < 70) random_phase(PH_DRAIN);
      else random_phase(PH_MIX);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("alloc_watch_table test passed");
    else
      $display("alloc_watch_table test failed");
    $finish;
  end

endmodule
